[rtl/core/bvs_pkg.sv]
// Package for the bounded vector store: sizes, request and response types,
// operation and status codes, and the command broadcast to the cell row.
// No dependencies.
package bvs_pkg;

  // Storage sizes
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned ELEM_W   = 32;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths of the request and response
  localparam int unsigned OP_W     = 3;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_POP    = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OP_W-1:0] OP_GET    = 3'd3;
  localparam logic [OP_W-1:0] OP_SET    = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [INDEX_W-1:0] index;
    logic [31:0]        value;
  } req_t;

  typedef struct packed {
    logic [31:0]         element;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } rsp_t;

  // Command seen by every cell in the row
  typedef struct packed {
    logic              load_en;
    logic [CNT_W-1:0]  load_pos;
    logic [ELEM_W-1:0] load_data;
    logic              shift_en;
    logic [CNT_W-1:0]  shift_pos;
    logic [CNT_W-1:0]  rd_pos;
  } cell_cmd_t;

endpackage

[rtl/core/bvs_cell.sv]
// One storage cell of the vector store row: holds a single element, loads
// it, takes its upper neighbor's element on a remove, and offers it for read.
// Depends on bvs_pkg.
module bvs_cell (
  input  logic                      clk_i,
  input  bvs_pkg::cell_cmd_t        cmd_i,
  input  logic [bvs_pkg::CNT_W-1:0] pos_i,
  input  logic [bvs_pkg::ELEM_W-1:0] next_i,
  output logic [bvs_pkg::ELEM_W-1:0] data_o,
  output logic [bvs_pkg::ELEM_W-1:0] rd_o
);
  import bvs_pkg::*;

  logic [ELEM_W-1:0] data_q;
  logic [ELEM_W-1:0] data_d;
  logic              load_hit;
  logic              shift_hit;

  // Decode this cell's share of the command
  assign load_hit  = cmd_i.load_en && (pos_i == cmd_i.load_pos);
  assign shift_hit = cmd_i.shift_en && (pos_i >= cmd_i.shift_pos);

  // Load wins; otherwise advance the neighbor's element down one place
  always_comb begin
    data_d = data_q;
    if (load_hit) begin
      data_d = cmd_i.load_data;
    end else if (shift_hit) begin
      data_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // Drive the read bus only when addressed
  assign rd_o   = (pos_i == cmd_i.rd_pos) ? data_q : '0;

endmodule

[rtl/core/bounded_vector_store_top.sv]
// Top level of the bounded vector store: request decode, fill count, the
// row of storage cells and a two-entry response buffer.
// Depends on bvs_pkg and bvs_cell.
//
// Usage:
//   Requests enter on in_valid_i / in_req_i and are taken at an edge where
//   in_stall_o is low. Each request is push, pop, remove, get or set and
//   yields exactly one response on out_valid_o / out_rsp_o: the element
//   read, a status and the count after the request.
//   Each response is registered in the output register, or in the skid entry.
//   Throughput: one request per cycle while in_stall_o is low. Each cell holds
//   one element and all update in the same cycle, closing a remove's gap.
//   The response buffer holds two entries: while out_stall_i is high the
//   block still takes one more request into its second entry, then raises
//   in_stall_o until the held response is taken.
//   Reset clears the fill count and the response buffer; cell contents are
//   not cleared, and only positions below the count are ever read.
module bounded_vector_store_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bvs_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bvs_pkg::rsp_t out_rsp_o
);
  import bvs_pkg::*;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  logic [CNT_W-1:0]  fill_q;
  logic [CNT_W-1:0]  fill_d;
  logic              accept;
  logic [CNT_W-1:0]  idx_ext;
  logic              in_range;
  logic              rd_en;
  logic [STATUS_W-1:0] status;
  cell_cmd_t         cmd;
  logic [ELEM_W-1:0] cell_data [CAPACITY];
  logic [ELEM_W-1:0] cell_rd   [CAPACITY];
  logic [ELEM_W-1:0] rd_data;
  rsp_t              rsp;

  rsp_t              out_q;
  logic              out_valid_q;
  rsp_t              skid_q;
  logic              skid_valid_q;
  logic              out_take;

  // Request handshake
  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;

  assign idx_ext  = CNT_W'(in_req_i.index);
  assign in_range = idx_ext < fill_q;

  // Decode the request into a cell command and the next count
  always_comb begin
    fill_d          = fill_q;
    status          = ST_DONE;
    rd_en           = 1'b0;
    cmd.load_en     = 1'b0;
    cmd.load_pos    = idx_ext;
    cmd.load_data   = ELEM_W'(in_req_i.value);
    cmd.shift_en    = 1'b0;
    cmd.shift_pos   = idx_ext;
    cmd.rd_pos      = idx_ext;
    unique case (in_req_i.operation)
      OP_PUSH: begin
        cmd.load_pos = fill_q;
        if (fill_q == CNT_FULL) begin
          status = ST_FULL;
        end else begin
          cmd.load_en = accept;
          fill_d      = fill_q + CNT_ONE;
        end
      end
      OP_POP: begin
        cmd.rd_pos = fill_q - CNT_ONE;
        if (fill_q == '0) begin
          status = ST_RANGE;
        end else begin
          rd_en  = 1'b1;
          fill_d = fill_q - CNT_ONE;
        end
      end
      OP_REMOVE: begin
        if (!in_range) begin
          status = ST_RANGE;
        end else begin
          rd_en        = 1'b1;
          cmd.shift_en = accept;
          fill_d       = fill_q - CNT_ONE;
        end
      end
      OP_GET: begin
        if (!in_range) begin
          status = ST_RANGE;
        end else begin
          rd_en = 1'b1;
        end
      end
      OP_SET: begin
        if (!in_range) begin
          status = ST_RANGE;
        end else begin
          cmd.load_en = accept;
        end
      end
      default: begin
        status = ST_RANGE;
      end
    endcase
  end

  // Row of cells; the top cell shifts in its own element
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [ELEM_W-1:0] next_data;
    if (k == CAPACITY - 1) begin : g_last
      assign next_data = cell_data[k];
    end else begin : g_mid
      assign next_data = cell_data[k+1];
    end
    bvs_cell u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .pos_i  (CNT_W'(k)),
      .next_i (next_data),
      .data_o (cell_data[k]),
      .rd_o   (cell_rd[k])
    );
  end

  // Merge the read bus: at most one cell drives it
  always_comb begin
    rd_data = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_data = rd_data | cell_rd[k];
    end
  end

  // Assemble the response
  always_comb begin
    rsp.element = rd_en ? 32'(rd_data) : '0;
    rsp.status  = status;
    rsp.count   = COUNT_W'(fill_d);
  end

  // Advance the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (accept) begin
      fill_q <= fill_d;
    end
  end

  // Response buffer: output register plus one skid entry
  assign out_take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (!out_valid_q || out_take) begin
        out_q <= rsp;
      end else begin
        skid_q <= rsp;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

[rtl/core/bvs_checker.sv]
// Port-level checks for the bounded vector store, bound to its top level.
// Depends on bvs_pkg and bounded_vector_store_top.
module bvs_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input bvs_pkg::req_t in_req_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input bvs_pkg::rsp_t out_rsp_o
);
  import bvs_pkg::*;

  // Count never exceeds capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.count <= COUNT_W'(CAPACITY)))
    else $error("count above capacity");

  // A refused push only happens on a full store
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_rsp_o.status == ST_FULL))
      |-> (out_rsp_o.count == COUNT_W'(CAPACITY)))
    else $error("full status with spare room");

  // Refused requests return no element
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_rsp_o.status != ST_DONE)) |-> (out_rsp_o.element == '0))
    else $error("element on refused request");

  // Hold a stalled response
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_rsp_o)))
    else $error("stalled response changed");

  // Hold a stalled request
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(in_req_i)))
    else $error("stalled request changed");

endmodule

bind bounded_vector_store_top bvs_checker u_bvs_checker (.*);
